// ----- sv/ldifp_pkg.sv -----
// Shared types, constants and helpers for the delimited integer field parser.
package ldifp_pkg;

  localparam int unsigned FIELD_COUNT_DEF = 5;
  localparam int unsigned OUT_FIELDS      = 5;
  localparam int unsigned FIELD_W         = 16;
  localparam int unsigned MAG_W           = 16;

  localparam logic [7:0] CHAR_A     = 8'h61;
  localparam logic [7:0] CHAR_NL    = 8'h0a;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;

  localparam logic [FIELD_W-1:0] FIELD_NONE = '1;
  localparam logic [MAG_W-1:0]   MAG_CAP    = 16'h8000;
  localparam logic [MAG_W-1:0]   POS_MAX    = 16'h7fff;

  typedef enum logic [3:0] {
    PH_SKIP  = 4'b0001,
    PH_SIGN  = 4'b0010,
    PH_DIGIT = 4'b0100,
    PH_STOP  = 4'b1000
  } num_phase_e;

  typedef struct packed {
    logic clear;
    logic stop;
    logic feed;
  } num_ctl_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0b) || (b == 8'h0c) || (b == 8'h0d);
  endfunction

endpackage

// ----- sv/ldifp_num.sv -----
// Decimal number accumulator: whitespace skip, sign, saturating digit accumulate.
module ldifp_num (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ldifp_pkg::num_ctl_t           ctl_i,
  input  logic [7:0]                    byte_i,
  output logic [ldifp_pkg::FIELD_W-1:0] value_o
);
  import ldifp_pkg::*;

  num_phase_e       phase_q, phase_d;
  logic             neg_q, neg_d;
  logic [MAG_W-1:0] mag_q, mag_d;
  logic [MAG_W+3:0] mag_next;
  logic             is_digit;

  assign is_digit = (byte_i >= CHAR_0) && (byte_i <= CHAR_9);
  assign mag_next = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0}
                  + {{(MAG_W){1'b0}}, 4'(byte_i - CHAR_0)};

  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    if (ctl_i.clear) begin
      phase_d = PH_SKIP;
      neg_d   = 1'b0;
      mag_d   = '0;
    end else if (ctl_i.stop) begin
      phase_d = PH_STOP;
    end else if (ctl_i.feed && phase_q != PH_STOP) begin
      if (is_digit) begin
        mag_d   = (mag_next > {4'b0000, MAG_CAP}) ? MAG_CAP : mag_next[MAG_W-1:0];
        phase_d = PH_DIGIT;
      end else if (phase_q == PH_SKIP && is_space(byte_i)) begin
        phase_d = PH_SKIP;
      end else if (phase_q == PH_SKIP && (byte_i == CHAR_PLUS || byte_i == CHAR_MINUS)) begin
        neg_d   = (byte_i == CHAR_MINUS);
        phase_d = PH_SIGN;
      end else begin
        phase_d = PH_STOP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SKIP;
      neg_q   <= 1'b0;
      mag_q   <= '0;
    end else begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      mag_q   <= mag_d;
    end
  end

  assign value_o = neg_q ? FIELD_W'(-mag_q) : ((mag_q > POS_MAX) ? POS_MAX : mag_q);

`ifndef SYNTHESIS
  a_mag_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mag_q <= MAG_CAP) else $error("magnitude above cap");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.clear |=> (mag_q == '0 && !neg_q)) else $error("number not cleared");
  a_sign_no_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_SIGN |-> mag_q == '0) else $error("magnitude set before digits");
`endif

endmodule

// ----- sv/letter_delimited_int_field_parser_unit.sv -----
// Top level: parses a byte stream into letter-delimited signed decimal fields per line.
// One received byte is taken per beat, one every cycle with no gaps needed while the
// input stall is low; a newline produces one result beat (the input register loads at
// acceptance, the result register when the newline advances out of it), all other bytes
// produce none. The per-byte work is a single pass through the delimiter check and the
// decimal accumulate. Input stall is raised only when a newline waits in the input
// register while the result register is still held by out_stall_i. An invalid line
// reports -1 in every field with both present flags low.
module letter_delimited_int_field_parser_unit #(
  parameter int unsigned FIELD_COUNT = ldifp_pkg::FIELD_COUNT_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [7:0]                           rx_byte_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [ldifp_pkg::FIELD_W-1:0] field_angle_o,
  output logic signed [ldifp_pkg::FIELD_W-1:0] yellow_angle_o,
  output logic signed [ldifp_pkg::FIELD_W-1:0] yellow_distance_o,
  output logic                                 yellow_present_o,
  output logic signed [ldifp_pkg::FIELD_W-1:0] blue_angle_o,
  output logic signed [ldifp_pkg::FIELD_W-1:0] blue_distance_o,
  output logic                                 blue_present_o
);
  import ldifp_pkg::*;

  localparam int unsigned EXP_W = $clog2(FIELD_COUNT + 1);

  logic               in_v_q;
  logic [7:0]         byte_q;
  logic               adv, is_nl, is_letter, all_seen, line_ok;
  logic [7:0]         letter_k, exp_ext;
  logic [EXP_W-1:0]   exp_q;
  logic               bad_q, bbf_q;
  logic               fld_wr;
  num_ctl_t           num_ctl;
  logic [FIELD_W-1:0] num_val;
  logic [FIELD_W-1:0] fld_q [FIELD_COUNT];
  logic [FIELD_W-1:0] res_fld [OUT_FIELDS];
  logic               out_v_q;
  logic [FIELD_W-1:0] res_q [OUT_FIELDS];
  logic               ypres_q, bpres_q;

  assign is_nl     = (byte_q == CHAR_NL);
  assign all_seen  = (exp_q == EXP_W'(FIELD_COUNT));
  assign is_letter = (byte_q >= CHAR_A) && (byte_q < CHAR_A + 8'(FIELD_COUNT));
  assign letter_k  = byte_q - CHAR_A;
  assign exp_ext   = 8'(exp_q);
  assign line_ok   = !bad_q && all_seen;

  assign adv        = in_v_q && (!is_nl || !(out_v_q && out_stall_i));
  assign in_stall_o = in_v_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_v_q <= 1'b1;
    end else if (adv) begin
      in_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= rx_byte_i;
    end
  end

  always_comb begin
    num_ctl = '0;
    fld_wr  = 1'b0;
    if (adv) begin
      if (is_nl) begin
        num_ctl.clear = 1'b1;
      end else if (!all_seen) begin
        if (is_letter && letter_k == exp_ext) begin
          num_ctl.clear = 1'b1;
          fld_wr        = 1'b1;
        end else if (is_letter && letter_k > exp_ext) begin
          num_ctl.stop = 1'b1;
        end else begin
          num_ctl.feed = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= '0;
      bad_q <= 1'b0;
      bbf_q <= 1'b0;
    end else if (adv) begin
      if (is_nl) begin
        exp_q <= '0;
        bad_q <= 1'b0;
        bbf_q <= 1'b0;
      end else if (!all_seen) begin
        if (fld_wr) begin
          if (exp_q == '0 && !bbf_q) begin
            bad_q <= 1'b1;
          end
          exp_q <= exp_q + EXP_W'(1);
        end else if (num_ctl.stop) begin
          bad_q <= 1'b1;
          if (exp_q == '0) begin
            bbf_q <= 1'b1;
          end
        end else if (exp_q == '0) begin
          bbf_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < FIELD_COUNT; i++) begin
      if (fld_wr && exp_q == EXP_W'(i)) begin
        fld_q[i] <= num_val;
      end
    end
  end

  ldifp_num u_num (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (num_ctl),
    .byte_i  (byte_q),
    .value_o (num_val)
  );

  for (genvar k = 0; k < OUT_FIELDS; k++) begin : g_res
    if (k < FIELD_COUNT) begin : g_used
      assign res_fld[k] = line_ok ? fld_q[k] : FIELD_NONE;
    end else begin : g_none
      assign res_fld[k] = FIELD_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv && is_nl) begin
      out_v_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && is_nl) begin
      for (int k = 0; k < OUT_FIELDS; k++) begin
        res_q[k] <= res_fld[k];
      end
      ypres_q <= (res_fld[1] != FIELD_NONE);
      bpres_q <= (res_fld[3] != FIELD_NONE);
    end
  end

  assign out_valid_o       = out_v_q;
  assign field_angle_o     = res_q[0];
  assign yellow_angle_o    = res_q[1];
  assign yellow_distance_o = res_q[2];
  assign yellow_present_o  = ypres_q;
  assign blue_angle_o      = res_q[3];
  assign blue_distance_o   = res_q[4];
  assign blue_present_o    = bpres_q;

`ifndef SYNTHESIS
  a_exp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_q <= EXP_W'(FIELD_COUNT)) else $error("delimiter index out of range");
  a_nl_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && is_nl |=> (exp_q == '0 && !bad_q && !bbf_q)) else $error("line state not cleared");
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_v_q && is_nl && out_v_q && out_stall_i)) else $error("spurious stall");
  a_out_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(adv && is_nl)) else $error("result without newline");
  a_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (yellow_present_o == (yellow_angle_o != FIELD_NONE)
              && blue_present_o == (blue_angle_o != FIELD_NONE)))
    else $error("present flag mismatch");
`endif

endmodule

// ----- test/letter_delimited_int_field_parser_unit_tb.sv -----
// Self-checking bench: text lines fed byte by byte, each parsed line checked against a line model.
module letter_delimited_int_field_parser_unit_tb;
  import ldifp_pkg::*;

  localparam int unsigned STIM_BYTES  = 1600;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned PRINT_CAP   = 100;

  typedef struct packed {
    logic [FIELD_W-1:0] field_angle;
    logic [FIELD_W-1:0] yellow_angle;
    logic [FIELD_W-1:0] yellow_distance;
    logic               yellow_present;
    logic [FIELD_W-1:0] blue_angle;
    logic [FIELD_W-1:0] blue_distance;
    logic               blue_present;
  } line_fields_t;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_stall_o;
  logic [7:0]                rx_byte_i   = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic signed [FIELD_W-1:0] field_angle_o;
  logic signed [FIELD_W-1:0] yellow_angle_o;
  logic signed [FIELD_W-1:0] yellow_distance_o;
  logic                      yellow_present_o;
  logic signed [FIELD_W-1:0] blue_angle_o;
  logic signed [FIELD_W-1:0] blue_distance_o;
  logic                      blue_present_o;

  letter_delimited_int_field_parser_unit dut (.*);

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  logic [7:0]   stim_all[$];
  logic [7:0]   line_buf[$];
  logic [7:0]   byte_q[$];
  line_fields_t expected_lines[$];
  int unsigned  send_idle_pct  = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  lines_seen     = 0;
  int unsigned  quiet_cycles   = 0;

  // line parser model state
  int unsigned        next_delim;
  bit                 line_bad;
  bit                 byte_before_first;
  num_phase_e         digit_phase;
  bit                 negative;
  int unsigned        magnitude;
  logic [FIELD_W-1:0] done_field[FIELD_COUNT_DEF];

  function automatic void clear_number();
    digit_phase = PH_SKIP;
    negative    = 1'b0;
    magnitude   = 0;
  endfunction

  function automatic void clear_line();
    next_delim        = 0;
    line_bad          = 1'b0;
    byte_before_first = 1'b0;
    clear_number();
  endfunction

  function automatic logic [FIELD_W-1:0] number_value();
    logic [FIELD_W-1:0] v;
    if (negative) begin
      v = FIELD_W'(0 - magnitude);
      return v;
    end
    return (magnitude > POS_MAX) ? POS_MAX : magnitude[FIELD_W-1:0];
  endfunction

  task automatic parse_byte(input logic [7:0] b);
    int unsigned        k;
    bit                 line_ok;
    bit                 ws;
    logic [FIELD_W-1:0] f[OUT_FIELDS];
    line_fields_t       r;
    if (b == CHAR_NL) begin
      line_ok = !line_bad && next_delim >= FIELD_COUNT_DEF;
      for (k = 0; k < OUT_FIELDS; k++) begin
        f[k] = (line_ok && k < FIELD_COUNT_DEF) ? done_field[k] : FIELD_NONE;
      end
      r.field_angle     = f[0];
      r.yellow_angle    = f[1];
      r.yellow_distance = f[2];
      r.yellow_present  = (f[1] != FIELD_NONE);
      r.blue_angle      = f[3];
      r.blue_distance   = f[4];
      r.blue_present    = (f[3] != FIELD_NONE);
      expected_lines.push_back(r);
      clear_line();
      return;
    end
    if (next_delim >= FIELD_COUNT_DEF) return;
    if (b >= CHAR_A && b < CHAR_A + FIELD_COUNT_DEF) begin
      k = 32'(b - CHAR_A);
      if (k == next_delim) begin
        if (k == 0 && !byte_before_first) line_bad = 1'b1;
        done_field[k] = number_value();
        clear_number();
        next_delim++;
        return;
      end
      if (k > next_delim) begin
        line_bad = 1'b1;
        if (next_delim == 0) byte_before_first = 1'b1;
        digit_phase = PH_STOP;
        return;
      end
      // a letter already passed is just a non-digit
    end
    if (next_delim == 0) byte_before_first = 1'b1;
    if (digit_phase == PH_STOP) return;
    ws = (b inside {8'h20, 8'h09, 8'h0b, 8'h0c, 8'h0d});
    if (b >= CHAR_0 && b <= CHAR_9) begin
      magnitude = magnitude * 10 + 32'(b - CHAR_0);
      if (magnitude > 32'(MAG_CAP)) magnitude = 32'(MAG_CAP);
      digit_phase = PH_DIGIT;
    end else if (digit_phase == PH_SKIP && (b == CHAR_PLUS || b == CHAR_MINUS)) begin
      negative    = (b == CHAR_MINUS);
      digit_phase = PH_SIGN;
    end else if (!(digit_phase == PH_SKIP && ws)) begin
      digit_phase = PH_STOP;
    end
  endtask

  function automatic logic [7:0] any_but_newline();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == CHAR_NL);
    return b;
  endfunction

  // noise inside field k that cannot act as the current or a later delimiter
  function automatic logic [7:0] junk_byte(input int unsigned k);
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == CHAR_NL || (b >= CHAR_A + k && b < CHAR_A + FIELD_COUNT_DEF));
    return b;
  endfunction

  function automatic logic [7:0] space_byte();
    case ($urandom_range(4))
      0: return 8'h20;
      1: return 8'h09;
      2: return 8'h0b;
      3: return 8'h0c;
      default: return 8'h0d;
    endcase
  endfunction

  task automatic add_field_text(input int unsigned k);
    int unsigned sel;
    int unsigned n;
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) line_buf.push_back(space_byte());
    sel = $urandom_range(9);
    if (sel == 0) begin
      line_buf.push_back(CHAR_MINUS);
      line_buf.push_back(8'(CHAR_0 + 1));
    end else begin
      if (sel == 1) line_buf.push_back(CHAR_PLUS);
      else if (sel < 4) line_buf.push_back(CHAR_MINUS);
      n = ($urandom_range(9) == 0) ? $urandom_range(6, 8) : $urandom_range(5);
      repeat (n) line_buf.push_back(8'(CHAR_0 + $urandom_range(9)));
    end
    if ($urandom_range(4) == 0) repeat ($urandom_range(1, 3)) line_buf.push_back(junk_byte(k));
  endtask

  task automatic build_line();
    int unsigned kind;
    int unsigned k;
    int unsigned delim_at[FIELD_COUNT_DEF];
    line_buf.delete();
    kind = $urandom_range(99);
    if (kind < 12) begin
      repeat ($urandom_range(12)) line_buf.push_back(any_but_newline());
    end else begin
      for (k = 0; k < FIELD_COUNT_DEF; k++) begin
        add_field_text(k);
        line_buf.push_back(8'(CHAR_A + k));
        delim_at[k] = line_buf.size() - 1;
      end
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 4)) line_buf.push_back(any_but_newline());
      if (kind < 30) begin
        case ($urandom_range(3))
          0: line_buf.delete(delim_at[$urandom_range(FIELD_COUNT_DEF - 1)]);
          1: line_buf.insert($urandom_range(line_buf.size()),
                             8'(CHAR_A + $urandom_range(FIELD_COUNT_DEF - 1)));
          2: line_buf.push_front(CHAR_A);
          default: line_buf.insert($urandom_range(line_buf.size()), any_but_newline());
        endcase
      end
    end
    line_buf.push_back(CHAR_NL);
    foreach (line_buf[i]) stim_all.push_back(line_buf[i]);
  endtask

  task automatic push_text(input string txt);
    int unsigned i;
    for (i = 0; i < txt.len(); i++) stim_all.push_back(txt[i]);
  endtask

  task automatic load_directed();
    // empty line
    stim_all.push_back(CHAR_NL);
    // leading space and plus, a -1 field, overflow, tab, earlier letter seen again,
    // 0xff and NUL as non-digits, bytes after the last delimiter
    push_text(" +7a-1b99999c\t5ad");
    stim_all.push_back(8'hff);
    stim_all.push_back(8'h00);
    push_text("e z\n");
    // 'a' as first byte, then a later letter too early
    push_text("ac\n");
  endtask

  task automatic flag_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP) $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input logic [FIELD_W-1:0] got,
                               input logic [FIELD_W-1:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("line %0d %s: got %0d, want %0d",
                              lines_seen, name, $signed(got), $signed(want)));
    end
  endtask

  task automatic check_line();
    line_fields_t want;
    if (expected_lines.size() == 0) begin
      flag_mismatch("result beat with no line pending");
      return;
    end
    want = expected_lines.pop_front();
    compare_field("field_angle", field_angle_o, want.field_angle);
    compare_field("yellow_angle", yellow_angle_o, want.yellow_angle);
    compare_field("yellow_distance", yellow_distance_o, want.yellow_distance);
    compare_field("yellow_present", {15'b0, yellow_present_o}, {15'b0, want.yellow_present});
    compare_field("blue_angle", blue_angle_o, want.blue_angle);
    compare_field("blue_distance", blue_distance_o, want.blue_distance);
    compare_field("blue_present", {15'b0, blue_present_o}, {15'b0, want.blue_present});
    lines_seen++;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      rx_byte_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) parse_byte(rx_byte_i);
      if (!in_valid_i || !in_stall_o) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          rx_byte_i  <= byte_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) check_line();
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int unsigned share;
    int unsigned p;
    clear_line();
    load_directed();
    while (stim_all.size() < STIM_BYTES) build_line();
    share = stim_all.size() / 4;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // phases split mid-line; each waits for every pending result before the next
    for (p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 83;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 83;
        end
        default: begin
          send_idle_pct  = 19;
          recv_stall_pct = 19;
        end
      endcase
      repeat ((p == 3) ? stim_all.size() : share) byte_q.push_back(stim_all.pop_front());
      while (byte_q.size() != 0 || in_valid_i || expected_lines.size() != 0) @(negedge clk_i);
    end
    repeat (8) @(posedge clk_i);
    if (expected_lines.size() != 0) flag_mismatch("results still pending at end");
    if (mismatch_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
